>>> src/mtep_pkg.sv
`timescale 1ns / 1ps
package mtep_pkg;

    typedef enum logic [2:0] {
        PH_DELTA  = 3'd0,
        PH_STATUS = 3'd1,
        PH_META   = 3'd2,
        PH_LENGTH = 3'd3,
        PH_ARGS   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        K_HEADER = 2'd0,
        K_ARG    = 2'd1,
        K_DONE   = 2'd2,
        K_ERROR  = 2'd3
    } t_kind;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_DELTA   = 3'd1;
    localparam logic [2:0] E_META    = 3'd2;
    localparam logic [2:0] E_LENGTH  = 3'd3;
    localparam logic [2:0] E_ORPHAN  = 3'd4;
    localparam logic [2:0] E_OVERRUN = 3'd5;

    localparam logic [7:0] ST_META  = 8'hFF;
    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_ESC   = 8'hF7;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] event_time;
        logic [7:0]  status;
        logic [7:0]  meta_type;
        logic [31:0] arg_count;
        logic [31:0] arg_index;
        logic [7:0]  arg_byte;
        logic [2:0]  error_code;
        logic        last_of_item;
    } t_result;

    // classified request from front to back: up to three results
    typedef struct packed {
        logic [1:0] n;       // number of results, 0..3
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_bundle;

endpackage

>>> src/mtep_if.sv
`timescale 1ns / 1ps
interface mtep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;
    modport source (output valid, data_byte, track_start, input ready);
    modport sink (input valid, data_byte, track_start, output ready);
endinterface

interface mtep_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] event_time;
    logic [7:0]  status;
    logic [7:0]  meta_type;
    logic [31:0] arg_count;
    logic [31:0] arg_index;
    logic [7:0]  arg_byte;
    logic [2:0]  error_code;
    logic        last_of_item;
    modport source (output valid, kind, event_time, status, meta_type, arg_count,
        arg_index, arg_byte, error_code, last_of_item, input ready);
    modport sink (input valid, kind, event_time, status, meta_type, arg_count,
        arg_index, arg_byte, error_code, last_of_item, output ready);
endinterface

>>> src/mtep_front.sv
`timescale 1ns / 1ps
module mtep_front
    import mtep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic [31:0] i_len,
    output t_bundle     o_bundle
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_pend, n_pend;
    logic [63:0] r_time, n_time;
    logic [7:0]  r_cur, n_cur;
    logic [7:0]  r_meta, n_meta;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_argc, n_argc;
    logic [7:0]  r_prev, n_prev;
    logic [1:0]  r_pargs, n_pargs;
    logic        r_have, n_have;
    logic        r_stop, n_stop;
    logic [31:0] r_evc, n_evc;

    // working copies after optional track start clear
    t_phase      c_phase;
    logic [31:0] c_pos, c_acc, c_pend, c_rem, c_argc, c_evc;
    logic [63:0] c_time;
    logic [7:0]  c_cur, c_meta, c_prev;
    logic [1:0]  c_pargs;
    logic        c_have, c_stop;

    logic [32:0] np;
    logic [33:0] np2;
    logic [31:0] acc7;
    logic [1:0]  k;
    logic [32:0] np_k;
    logic [33:0] np_acc;
    logic [1:0]  cnt;
    t_result     res [3];

    function automatic t_result mk(input t_kind kd, input logic [63:0] t,
        input logic [7:0] st, input logic [7:0] mt, input logic [31:0] c,
        input logic [31:0] ix, input logic [7:0] b, input logic [2:0] e);
        t_result x;
        x.kind = kd; x.event_time = t; x.status = st; x.meta_type = mt;
        x.arg_count = c; x.arg_index = ix; x.arg_byte = b; x.error_code = e;
        x.last_of_item = 1'b0;
        return x;
    endfunction

    // parser step
    always_comb begin
        c_phase = r_phase; c_pos = r_pos; c_acc = r_acc; c_pend = r_pend;
        c_time = r_time; c_cur = r_cur; c_meta = r_meta; c_rem = r_rem;
        c_argc = r_argc; c_prev = r_prev; c_pargs = r_pargs; c_have = r_have;
        c_stop = r_stop; c_evc = r_evc;
        if (i_start) begin
            c_phase = PH_DELTA; c_pos = '0; c_acc = '0; c_pend = '0; c_time = '0;
            c_cur = '0; c_meta = '0; c_rem = '0; c_argc = '0; c_prev = '0;
            c_pargs = '0; c_have = 1'b0; c_stop = 1'b0; c_evc = '0;
        end
        n_phase = c_phase; n_pos = c_pos; n_acc = c_acc; n_pend = c_pend;
        n_time = c_time; n_cur = c_cur; n_meta = c_meta; n_rem = c_rem;
        n_argc = c_argc; n_prev = c_prev; n_pargs = c_pargs; n_have = c_have;
        n_stop = c_stop; n_evc = c_evc;
        cnt = 2'd0;
        res[0] = '0; res[1] = '0; res[2] = '0;
        np = {1'b0, c_pos} + 33'd1;
        np2 = {1'b0, np} + 34'd2;
        acc7 = {c_acc[24:0], i_byte[6:0]};
        k = 2'd2;
        np_k = '0;
        np_acc = {1'b0, np} + {2'b0, acc7};
        if (!c_stop) begin
            if (c_pos >= i_len) begin
                n_stop = 1'b1; cnt = 2'd1;
                if (c_phase == PH_DELTA && c_argc == '0)
                    res[0] = mk(K_DONE, c_time, '0, '0, '0, '0, '0, E_NONE);
                else if (c_phase == PH_DELTA || c_phase == PH_STATUS)
                    res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_DELTA);
                else if (c_phase == PH_META)
                    res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_META);
                else if (c_phase == PH_LENGTH)
                    res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_LENGTH);
                else
                    res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_OVERRUN);
            end else begin
                n_pos = np[31:0];
                case (c_phase)
                    PH_DELTA: begin
                        n_acc = acc7;
                        if (i_byte[7]) begin
                            if (np >= {1'b0, i_len}) begin
                                n_stop = 1'b1; cnt = 2'd1;
                                res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_DELTA);
                            end else n_argc = c_argc + 32'd1;
                        end else if (np2 > {2'b0, i_len}) begin
                            n_stop = 1'b1; cnt = 2'd1;
                            res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_DELTA);
                        end else begin
                            n_pend = acc7; n_acc = '0; n_argc = '0; n_phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        n_meta = '0; n_argc = '0; n_acc = '0;
                        if (i_byte == ST_META) begin
                            if (np2 > {2'b0, i_len}) begin
                                n_stop = 1'b1; cnt = 2'd1;
                                res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_META);
                            end else begin
                                n_cur = i_byte; n_phase = PH_META;
                            end
                        end else if (i_byte == ST_SYSEX || i_byte == ST_ESC) begin
                            n_cur = i_byte; n_phase = PH_LENGTH;
                        end else if (i_byte[7]) begin
                            k = (i_byte[7:4] inside {4'hC, 4'hD}) ? 2'd1 : 2'd2;
                            np_k = np + {31'b0, k};
                            if (np_k > {1'b0, i_len}) begin
                                n_stop = 1'b1; cnt = 2'd1;
                                res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_OVERRUN);
                            end else begin
                                n_cur = i_byte; n_evc = {30'b0, k}; n_rem = {30'b0, k};
                                n_time = c_time + {32'b0, c_pend}; cnt = 2'd1;
                                res[0] = mk(K_HEADER, n_time, i_byte, '0, {30'b0, k},
                                    '0, '0, E_NONE);
                                n_phase = PH_ARGS;
                            end
                        end else if (!c_have || c_prev == ST_SYSEX || c_prev == ST_ESC ||
                                     c_prev == ST_META) begin
                            n_stop = 1'b1; cnt = 2'd1;
                            res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_ORPHAN);
                        end else begin
                            k = (c_pargs != 2'd0) ? c_pargs - 2'd1 : 2'd0;
                            np_k = np + {31'b0, k};
                            if (np_k > {1'b0, i_len}) begin
                                n_stop = 1'b1; cnt = 2'd1;
                                res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_OVERRUN);
                            end else begin
                                n_cur = c_prev; n_evc = {30'b0, k} + 32'd1;
                                n_time = c_time + {32'b0, c_pend};
                                res[0] = mk(K_HEADER, n_time, c_prev, '0, n_evc, '0, '0,
                                    E_NONE);
                                res[1] = mk(K_ARG, n_time, c_prev, '0, n_evc, '0, i_byte,
                                    E_NONE);
                                cnt = 2'd2;
                                n_argc = 32'd1; n_rem = {30'b0, k};
                                if (k == 2'd0) begin
                                    n_prev = c_prev; n_have = 1'b1;
                                    n_pargs = n_evc[1:0];
                                    n_phase = PH_DELTA; n_acc = '0; n_argc = '0;
                                    if (np >= {1'b0, i_len}) begin
                                        res[2] = mk(K_DONE, n_time, '0, '0, '0, '0, '0,
                                            E_NONE);
                                        cnt = 2'd3; n_stop = 1'b1;
                                    end
                                end else n_phase = PH_ARGS;
                            end
                        end
                    end
                    PH_META: begin
                        n_meta = i_byte; n_acc = '0; n_phase = PH_LENGTH;
                    end
                    PH_LENGTH: begin
                        n_acc = acc7;
                        if (i_byte[7]) begin
                            if (np >= {1'b0, i_len}) begin
                                n_stop = 1'b1; cnt = 2'd1;
                                res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_LENGTH);
                            end
                        end else if (np_acc > {2'b0, i_len}) begin
                            n_stop = 1'b1; cnt = 2'd1;
                            res[0] = mk(K_ERROR, c_time, '0, '0, '0, '0, '0, E_OVERRUN);
                        end else begin
                            n_evc = acc7; n_rem = acc7; n_argc = '0;
                            n_time = c_time + {32'b0, c_pend}; cnt = 2'd1;
                            res[0] = mk(K_HEADER, n_time, c_cur, c_meta, acc7, '0, '0,
                                E_NONE);
                            if (acc7 == '0) begin
                                n_prev = c_cur; n_have = 1'b1;
                                n_phase = PH_DELTA; n_acc = '0;
                                if (np >= {1'b0, i_len}) begin
                                    res[1] = mk(K_DONE, n_time, '0, '0, '0, '0, '0, E_NONE);
                                    cnt = 2'd2; n_stop = 1'b1;
                                end
                            end else n_phase = PH_ARGS;
                        end
                    end
                    default: begin
                        cnt = 2'd1;
                        res[0] = mk(K_ARG, c_time, c_cur, c_meta, c_evc, c_argc, i_byte,
                            E_NONE);
                        n_argc = c_argc + 32'd1;
                        n_rem = c_rem - 32'd1;
                        if (n_rem == '0) begin
                            n_prev = c_cur; n_have = 1'b1;
                            if (c_cur != ST_SYSEX && c_cur != ST_ESC && c_cur != ST_META)
                                n_pargs = c_evc[1:0];
                            n_phase = PH_DELTA; n_acc = '0; n_argc = '0;
                            if (np >= {1'b0, i_len}) begin
                                res[1] = mk(K_DONE, c_time, '0, '0, '0, '0, '0, E_NONE);
                                cnt = 2'd2; n_stop = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
        case (cnt)
            2'd1: res[0].last_of_item = 1'b1;
            2'd2: res[1].last_of_item = 1'b1;
            2'd3: res[2].last_of_item = 1'b1;
            default: ;
        endcase
        o_bundle.n = cnt;
        o_bundle.r0 = res[0];
        o_bundle.r1 = res[1];
        o_bundle.r2 = res[2];
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA; r_pos <= '0; r_acc <= '0; r_pend <= '0;
            r_time <= '0; r_cur <= '0; r_meta <= '0; r_rem <= '0; r_argc <= '0;
            r_prev <= '0; r_pargs <= '0; r_have <= 1'b0; r_stop <= 1'b0;
            r_evc <= '0;
        end else if (i_take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_acc <= n_acc; r_pend <= n_pend;
            r_time <= n_time; r_cur <= n_cur; r_meta <= n_meta; r_rem <= n_rem;
            r_argc <= n_argc; r_prev <= n_prev; r_pargs <= n_pargs;
            r_have <= n_have; r_stop <= n_stop; r_evc <= n_evc;
        end
    end

endmodule

>>> src/mtep_back.sv
`timescale 1ns / 1ps
module mtep_back
    import mtep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_ready,
    mtep_out_if.source o_out
);

    // two-entry bundle queue
    t_bundle    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] r_sub;
    t_bundle    head;
    t_result    cur;
    logic       pop;

    assign head = r_q[r_rp];
    always_comb begin
        case (r_sub)
            2'd0: cur = head.r0;
            2'd1: cur = head.r1;
            default: cur = head.r2;
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.kind = cur.kind;
    assign o_out.event_time = cur.event_time;
    assign o_out.status = cur.status;
    assign o_out.meta_type = cur.meta_type;
    assign o_out.arg_count = cur.arg_count;
    assign o_out.arg_index = cur.arg_index;
    assign o_out.arg_byte = cur.arg_byte;
    assign o_out.error_code = cur.error_code;
    assign o_out.last_of_item = cur.last_of_item;

    logic take_out;
    logic do_push;
    assign take_out = o_out.valid && o_out.ready;
    assign pop = take_out && (r_sub + 2'd1 == head.n);
    assign do_push = i_push && (i_bundle.n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_bundle;
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (pop) begin
                r_rp <= ~r_rp; r_sub <= '0;
            end else if (take_out) r_sub <= r_sub + 2'd1;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |-> (r_cnt != 2'd2) || pop) else $error("queue overflow");
    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) |-> (r_sub < head.n)) else $error("sub index past bundle");
    a_last_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> cur.last_of_item) else $error("pop without last mark");

endmodule

>>> src/midi_track_event_parser.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// in        in   valid/ready        data_byte, track_start
// out       out  valid/ready        kind, event_time, status, meta_type, arg_count,
//                                   arg_index, arg_byte, error_code, last_of_item
// cfg       in   i_cfg_we           i_cfg_data = track_length
//
// one byte a cycle: the front decodes a byte in the cycle it is taken and queues
// its 0..3 results; the back sends one result a cycle from a two-deep queue.
// rate is set by the output port: a byte's entry pops once its n results are out.
// synchronous active-low reset clears parser state, queue and track length.
// input stalls only when the queue is full, so output stalls reach the parser
// only through a full queue.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    mtep_in_if.sink     i_in,
    mtep_out_if.source  o_out
);

    logic [31:0] r_len;
    t_bundle     bundle;
    logic        q_ready;
    logic        take;

    // track length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len <= '0;
        else if (i_cfg_we) r_len <= i_cfg_data;
    end

    assign i_in.ready = q_ready;
    assign take = i_in.valid && q_ready;

    mtep_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_in.data_byte),
        .i_start  (i_in.track_start),
        .i_len    (r_len),
        .o_bundle (bundle)
    );

    mtep_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take),
        .i_bundle (bundle),
        .o_ready  (q_ready),
        .o_out    (o_out)
    );

endmodule

>>> dv/midi_track_event_parser_test.sv
`timescale 1ns / 1ps
module midi_track_event_parser_test;
    import mtep_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       track_start;
        logic       cfg_we;
        logic [31:0] cfg_len;
    } t_byte_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;

    mtep_in_if  in_ch();
    mtep_out_if out_ch();

    midi_track_event_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [31:0] m_len;
    t_phase      m_phase;
    logic [31:0] m_pos, m_acc, m_delta, m_rem, m_argc, m_count;
    logic [63:0] m_time;
    logic [7:0]  m_status, m_meta, m_prev;
    logic [1:0]  m_prev_args;
    logic        m_have_prev, m_stopped;

    t_result     expected_results[$];
    t_byte_req   pending_bytes[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_bytes = 0;
    int          n_events = 0;
    int          n_fail_marks = 0;
    bit          calm = 0;
    bit          timed_out = 0;

    task automatic clear_parser();
        m_phase = PH_DELTA; m_pos = 0; m_acc = 0; m_delta = 0; m_rem = 0; m_argc = 0;
        m_count = 0; m_time = 0; m_status = 0; m_meta = 0; m_prev = 0;
        m_prev_args = 0; m_have_prev = 0; m_stopped = 0;
    endtask

    task automatic push_result(input t_kind k, input logic [7:0] st, input logic [7:0] mt,
                               input logic [31:0] cnt, input logic [31:0] idx,
                               input logic [7:0] b, input logic [2:0] err);
        t_result r;
        r = '0;
        r.kind = k; r.event_time = m_time; r.status = st; r.meta_type = mt;
        r.arg_count = cnt; r.arg_index = idx; r.arg_byte = b; r.error_code = err;
        expected_results.push_back(r);
    endtask

    task automatic raise_error(input logic [2:0] code);
        push_result(K_ERROR, 0, 0, 0, 0, 0, code);
        m_stopped = 1;
        n_fail_marks++;
    endtask

    task automatic emit_header();
        m_time = m_time + 64'(m_delta);
        push_result(K_HEADER, m_status, m_meta, m_count, 0, 0, E_NONE);
        n_events++;
    endtask

    task automatic close_event();
        m_prev = m_status;
        m_have_prev = 1;
        if (m_status != ST_SYSEX && m_status != ST_ESC && m_status != ST_META)
            m_prev_args = m_count[1:0];
        m_phase = PH_DELTA; m_acc = 0; m_argc = 0;
        if (m_pos >= m_len) begin
            push_result(K_DONE, 0, 0, 0, 0, 0, E_NONE);
            m_stopped = 1;
        end
    endtask

    // expected results of one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic start);
        int n_before;
        logic [32:0] np;
        logic [31:0] k;
        n_before = expected_results.size();
        if (start) clear_parser();
        if (m_stopped) return;
        if (m_pos >= m_len) begin
            if (m_phase == PH_DELTA && m_argc == 0) begin
                push_result(K_DONE, 0, 0, 0, 0, 0, E_NONE);
                m_stopped = 1;
            end else if (m_phase == PH_DELTA || m_phase == PH_STATUS) raise_error(E_DELTA);
            else if (m_phase == PH_META) raise_error(E_META);
            else if (m_phase == PH_LENGTH) raise_error(E_LENGTH);
            else raise_error(E_OVERRUN);
        end else begin
            np = {1'b0, m_pos} + 33'd1;
            m_pos = np[31:0];
            case (m_phase)
                PH_DELTA: begin
                    m_acc = (m_acc << 7) | {25'd0, b[6:0]};
                    if (b[7]) begin
                        if (np >= {1'b0, m_len}) raise_error(E_DELTA);
                        else m_argc++;
                    end else if (np + 2 > {1'b0, m_len}) begin
                        raise_error(E_DELTA);
                    end else begin
                        m_delta = m_acc; m_acc = 0; m_argc = 0; m_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    m_meta = 0; m_argc = 0; m_acc = 0;
                    if (b == ST_META) begin
                        if (np + 2 > {1'b0, m_len}) raise_error(E_META);
                        else begin m_status = b; m_phase = PH_META; end
                    end else if (b == ST_SYSEX || b == ST_ESC) begin
                        m_status = b; m_phase = PH_LENGTH;
                    end else if (b[7]) begin
                        k = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 1 : 2;
                        if (np + k > {1'b0, m_len}) raise_error(E_OVERRUN);
                        else begin
                            m_status = b; m_count = k; m_rem = k;
                            emit_header(); m_phase = PH_ARGS;
                        end
                    end else if (!m_have_prev || m_prev == ST_SYSEX || m_prev == ST_ESC
                                 || m_prev == ST_META) begin
                        raise_error(E_ORPHAN);
                    end else begin
                        k = (m_prev_args != 0) ? 32'(m_prev_args) - 1 : 0;
                        if (np + k > {1'b0, m_len}) raise_error(E_OVERRUN);
                        else begin
                            m_status = m_prev; m_count = k + 1;
                            emit_header();
                            push_result(K_ARG, m_status, 0, m_count, 0, b, E_NONE);
                            m_argc = 1; m_rem = k;
                            if (k == 0) close_event(); else m_phase = PH_ARGS;
                        end
                    end
                end
                PH_META: begin
                    m_meta = b; m_acc = 0; m_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    m_acc = (m_acc << 7) | {25'd0, b[6:0]};
                    if (b[7]) begin
                        if (np >= {1'b0, m_len}) raise_error(E_LENGTH);
                    end else if (np + {1'b0, m_acc} > {1'b0, m_len}) begin
                        raise_error(E_OVERRUN);
                    end else begin
                        m_count = m_acc; m_rem = m_acc; m_argc = 0;
                        emit_header();
                        if (m_rem == 0) close_event(); else m_phase = PH_ARGS;
                    end
                end
                default: begin
                    push_result(K_ARG, m_status, m_meta, m_count, m_argc, b, E_NONE);
                    m_argc++;
                    m_rem--;
                    if (m_rem == 0) close_event();
                end
            endcase
        end
        if (expected_results.size() > n_before)
            expected_results[expected_results.size() - 1].last_of_item = 1'b1;
    endtask

    // byte driver with random idle bursts; config requests wait for an idle block
    int gap_left = 0;
    int cfg_hold = 0;
    bit cfg_fire = 1'b0;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.track_start = 1'b0;
    end
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cfg_fire = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                parse_byte(in_ch.data_byte, in_ch.track_start);
                n_bytes++;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (pending_bytes.size() > 0 && pending_bytes[0].cfg_we) begin
                    in_ch.valid <= 1'b0;
                    if (!(in_ch.valid && in_ch.ready) && expected_results.size() == 0) begin
                        if (cfg_hold < 8) cfg_hold++;
                        else begin
                            cfg_fire = 1'b1;
                            i_cfg_data <= pending_bytes[0].cfg_len;
                            m_len = pending_bytes[0].cfg_len;
                            void'(pending_bytes.pop_front());
                            cfg_hold = 0;
                        end
                    end else cfg_hold = 0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= pending_bytes[0].data_byte;
                    in_ch.track_start <= pending_bytes[0].track_start;
                    void'(pending_bytes.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            i_cfg_we <= cfg_fire;
        end
    end

    // result monitor with random back-pressure
    int stall_left = 0;
    initial out_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.kind = out_ch.kind; got.event_time = out_ch.event_time;
                got.status = out_ch.status; got.meta_type = out_ch.meta_type;
                got.arg_count = out_ch.arg_count; got.arg_index = out_ch.arg_index;
                got.arg_byte = out_ch.arg_byte; got.error_code = out_ch.error_code;
                got.last_of_item = out_ch.last_of_item;
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic start = 1'b0);
        t_byte_req r;
        r.data_byte = b; r.track_start = start; r.cfg_we = 0; r.cfg_len = 0;
        pending_bytes.push_back(r);
    endtask

    task automatic add_length(input logic [31:0] len);
        t_byte_req r;
        r.data_byte = 0; r.track_start = 0; r.cfg_we = 1; r.cfg_len = len;
        pending_bytes.push_back(r);
    endtask

    // one random event, bytes appended to trk; a running-status event may be malformed
    task automatic make_event(ref logic [7:0] trk[$], input bit allow_running);
        int sel, n, i;
        logic [7:0] st;
        sel = $urandom_range(0, 9);
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) trk.push_back(8'h80 | 8'($urandom_range(0, 127)));
        trk.push_back(8'($urandom_range(0, 127)));
        if (sel < 5 || (sel < 7 && !allow_running)) begin
            st = 8'h80 | 8'($urandom_range(0, 111));
            trk.push_back(st);
            trk.push_back(8'($urandom_range(0, 255)));
            if (!(st[7:4] == 4'hC || st[7:4] == 4'hD)) trk.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 7) begin
            trk.push_back(8'($urandom_range(0, 127)));
            if ($urandom_range(0, 1)) trk.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 9) begin
            trk.push_back(ST_META);
            trk.push_back(8'($urandom_range(0, 255)));
            n = $urandom_range(0, 3);
            trk.push_back(8'(n));
            for (i = 0; i < n; i++) trk.push_back(8'($urandom_range(0, 255)));
        end else begin
            trk.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_ESC);
            n = $urandom_range(0, 3);
            trk.push_back(8'(n));
            for (i = 0; i < n; i++) trk.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] trk[$];
        int i, e, total;
        bit chan_last;
        clear_parser();
        m_len = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty track, then a hand-built track that stops on an orphan data byte
        add_byte(8'h00, 1'b1);
        add_length(32'd30);
        trk = '{8'h00, 8'h25, 8'h00, 8'h40,
                8'h81, 8'h00, 8'h7F, 8'hFF,
                8'h00, 8'hC3, 8'hFF,
                8'h00, 8'hFF, 8'h51, 8'h02, 8'h0A, 8'hFF,
                8'h00, 8'h40,
                8'h00, 8'hF7, 8'h00};
        foreach (trk[i]) add_byte(trk[i], i == 0);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h11);
        add_length(32'd4);
        add_byte(8'h00, 1'b1);
        add_byte(8'h40);
        add_byte(8'h10);
        add_byte(8'hFF, 1'b1);
        add_length(32'hFFFF_FFFF);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(8'h7F);
        add_byte(8'hF0);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_length(32'd6);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF);
        add_byte(8'h01);
        add_byte(8'h85);

        // random tracks, mostly well formed
        total = 0;
        while (total < 140) begin
            trk.delete();
            chan_last = 0;
            e = $urandom_range(1, 5);
            for (i = 0; i < e; i++) begin
                make_event(trk, chan_last);
                chan_last = (trk.size() > 0);
            end
            if ($urandom_range(0, 4) == 0)
                trk[$urandom_range(0, trk.size() - 1)] = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 5))
                0: add_length(32'(trk.size()) - 32'($urandom_range(0, 3)));
                1: add_length(32'hFFFF_FFFF);
                default: add_length(32'(trk.size()));
            endcase
            foreach (trk[i]) add_byte(trk[i], i == 0);
            add_byte(8'($urandom_range(0, 255)));
            total += trk.size() + 1;
        end
        add_length(32'd0);
        add_byte(8'h00, 1'b1);

        while (pending_bytes.size() > 60) @(posedge i_clk);
        calm = 1;
        while (pending_bytes.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("fed %0d bytes, checked %0d results: %0d event headers, %0d error marks",
                 n_bytes, n_results, n_events, n_fail_marks);
        if (errors == 0 && !timed_out) begin
            $display("midi_track_event_parser test passed");
        end else begin
            $display("midi_track_event_parser test failed");
        end
        $finish;
    end

    initial begin
        #400000;
        timed_out = 1;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("midi_track_event_parser test failed");
        $finish;
    end

endmodule
